// ===== rtl/isort_pkg.sv =====
// ----------------------------------------------------------------------------
// isort_pkg: shared types and constants for the insertion sorter
// Beat layouts for both channels, store sizing and the RAM request bundle.
// ----------------------------------------------------------------------------
package isort_pkg;

	localparam int MAX_ITEMS = 64;
	localparam int DATA_W    = 32;
	localparam int ADDR_W    = $clog2(MAX_ITEMS);
	localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     last;
	} in_beat_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] sorted_value;
		logic                     final_res;
		logic                     overflow;
	} out_beat_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [DATA_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} ram_req_t;

endpackage

// ===== rtl/isort_ram.sv =====
// ----------------------------------------------------------------------------
// isort_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module isort_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/isort_core.sv =====
// ----------------------------------------------------------------------------
// isort_core: insertion and emission sequencer
// Shifts larger entries up one slot at a time through the store, using a
// single signed compare, then reads the set back out in order.
// ----------------------------------------------------------------------------
module isort_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  isort_pkg::in_beat_t           in_beat,
	output logic                          out_valid,
	input  logic                          out_stall,
	output isort_pkg::out_beat_t          out_beat,
	output isort_pkg::ram_req_t           ram_req,
	input  logic [isort_pkg::DATA_W-1:0]  ram_rdata
);

	import isort_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_RD,
		S_INS_CMP,
		S_EMIT_RD,
		S_EMIT_LD,
		S_EMIT_WAIT
	} state_t;

	state_t                   state_q;
	logic signed [DATA_W-1:0] v_q;
	logic                     last_q;
	logic [ADDR_W-1:0]        pos_q;
	logic [CNT_W-1:0]         count_q;
	logic                     drop_q;
	logic [ADDR_W-1:0]        k_q;
	logic                     out_valid_q;
	out_beat_t                out_q;

	logic in_acc;
	logic shift_up;
	logic is_last_k;

	assign in_acc    = in_valid && (state_q == S_IDLE);
	assign in_stall  = (state_q != S_IDLE);
	assign shift_up  = $signed(ram_rdata) > v_q;
	assign is_last_k = ({1'b0, k_q} + CNT_W'(1)) == count_q;

	always_comb begin
		ram_req       = '0;
		ram_req.raddr = k_q;
		ram_req.waddr = pos_q;
		ram_req.wdata = v_q;
		unique case (state_q)
			S_INS_RD: begin
				if (pos_q == '0) begin
					ram_req.we = 1'b1;
				end else begin
					ram_req.re    = 1'b1;
					ram_req.raddr = pos_q - ADDR_W'(1);
				end
			end
			S_INS_CMP: begin
				ram_req.we = 1'b1;
				if (shift_up) begin
					ram_req.wdata = ram_rdata;
				end
			end
			S_EMIT_RD: begin
				ram_req.re = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			drop_q      <= 1'b0;
			out_valid_q <= 1'b0;
			pos_q       <= '0;
			k_q         <= '0;
			last_q      <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						v_q    <= in_beat.value;
						last_q <= in_beat.last;
						k_q    <= '0;
						if (count_q == CNT_W'(MAX_ITEMS)) begin
							// store full: beat is dropped
							drop_q  <= 1'b1;
							state_q <= in_beat.last ? S_EMIT_RD : S_IDLE;
						end else begin
							pos_q   <= count_q[ADDR_W-1:0];
							state_q <= S_INS_RD;
						end
					end
				end
				S_INS_RD: begin
					if (pos_q == '0) begin
						count_q <= count_q + CNT_W'(1);
						state_q <= last_q ? S_EMIT_RD : S_IDLE;
					end else begin
						state_q <= S_INS_CMP;
					end
				end
				S_INS_CMP: begin
					if (shift_up) begin
						pos_q   <= pos_q - ADDR_W'(1);
						state_q <= S_INS_RD;
					end else begin
						// equal keys stop here, so arrival order is kept
						count_q <= count_q + CNT_W'(1);
						state_q <= last_q ? S_EMIT_RD : S_IDLE;
					end
				end
				S_EMIT_RD: begin
					state_q <= S_EMIT_LD;
				end
				S_EMIT_LD: begin
					out_q.sorted_value <= $signed(ram_rdata);
					out_q.final_res    <= is_last_k;
					out_q.overflow     <= drop_q;
					out_valid_q        <= 1'b1;
					state_q            <= S_EMIT_WAIT;
				end
				S_EMIT_WAIT: begin
					if (!out_stall) begin
						out_valid_q <= 1'b0;
						if (out_q.final_res) begin
							count_q <= '0;
							drop_q  <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							k_q     <= k_q + ADDR_W'(1);
							state_q <= S_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_beat  = out_q;

endmodule

// ===== rtl/insertion_sorter.sv =====
// ----------------------------------------------------------------------------
// insertion_sorter: stable ascending sort of signed 32-bit sets
// Collects up to 64 values, keeping the store sorted as each beat arrives,
// and streams the set out in order once the beat marked last is taken.
// ----------------------------------------------------------------------------
// Each input beat is inserted by walking down from the end of the store: the
// RAM read port fetches one neighbor, the signed compare decides, and a larger
// neighbor moves up one slot. After the accepting cycle, an insertion holds
// in_stall high through a read and a compare state for each element that is
// larger than the new value, then writes the new value in the compare state
// when it stops above slot 0 or in the read state when it lands in slot 0. A
// beat arriving at a full store is dropped without a write and flags overflow
// on every result of that set. After the last beat, each result passes through
// RAM read, load and hand-off, and then waits out any out_stall; the input is
// stalled until the final result is taken.
// ----------------------------------------------------------------------------
module insertion_sorter (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  isort_pkg::in_beat_t   in_beat,
	output logic                  out_valid,
	input  logic                  out_stall,
	output isort_pkg::out_beat_t  out_beat
);

	import isort_pkg::*;

	ram_req_t          ram_req;
	logic [DATA_W-1:0] ram_rdata;

	isort_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_beat   (in_beat),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_beat  (out_beat),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata)
	);

	isort_ram #(
		.WIDTH (DATA_W),
		.DEPTH (MAX_ITEMS)
	) u_store (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

endmodule
